>>> rtl/rvenc_pkg.sv
// Package for the RV32I instruction encoder: format and mnemonic codes,
// opcode constants, queue entry type and the mnemonic lookup table.
// No dependencies.
package rvenc_pkg;

    typedef enum logic [3:0] {
        FMT_R,
        FMT_I,
        FMT_SH,
        FMT_S,
        FMT_B,
        FMT_U,
        FMT_J,
        FMT_NOP,
        FMT_MV,
        FMT_NOT
    } fmt_t;

    typedef enum logic [5:0] {
        MN_ADD, MN_SUB, MN_XOR, MN_OR, MN_AND, MN_SLL, MN_SRL, MN_SRA, MN_SLT, MN_SLTU,
        MN_ADDI, MN_XORI, MN_ORI, MN_ANDI, MN_SLLI, MN_SRLI, MN_SRAI, MN_SLTI, MN_SLTIU,
        MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_JALR,
        MN_SB, MN_SH, MN_SW,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_LUI, MN_AUIPC, MN_JAL, MN_NOP, MN_MV, MN_NOT
    } mnemonic_t;

    localparam logic [6:0]  OPC_OP      = 7'h33;
    localparam logic [6:0]  OPC_OP_IMM  = 7'h13;
    localparam logic [6:0]  OPC_LOAD    = 7'h03;
    localparam logic [6:0]  OPC_JALR    = 7'h67;
    localparam logic [6:0]  OPC_STORE   = 7'h23;
    localparam logic [6:0]  OPC_BRANCH  = 7'h63;
    localparam logic [6:0]  OPC_LUI     = 7'h37;
    localparam logic [6:0]  OPC_AUIPC   = 7'h17;
    localparam logic [6:0]  OPC_JAL     = 7'h6F;
    localparam logic [6:0]  F7_ZERO     = 7'h00;
    localparam logic [6:0]  F7_ALT      = 7'h20;
    localparam logic [31:0] NOP_WORD    = 32'h0000_0013;
    localparam logic [11:0] IMM_ONES    = 12'hFFF;
    localparam logic [31:0] WORD_STRIDE = 32'd4;

    typedef struct packed {
        fmt_t       fmt;
        logic [6:0] opcode;
        logic [2:0] f3;
        logic [6:0] f7;
    } enc_entry_t;

    // One beat as it travels from the front to the back
    typedef struct packed {
        logic        is_origin;
        enc_entry_t  enc;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] addr;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } push_t;

    function automatic enc_entry_t enc_lookup(input logic [5:0] mn);
        enc_entry_t e;
        e = '{fmt: FMT_NOP, opcode: OPC_OP_IMM, f3: 3'd0, f7: F7_ZERO};
        case (mn)
            MN_ADD:   e = '{FMT_R,   OPC_OP,     3'd0, F7_ZERO};
            MN_SUB:   e = '{FMT_R,   OPC_OP,     3'd0, F7_ALT};
            MN_XOR:   e = '{FMT_R,   OPC_OP,     3'd4, F7_ZERO};
            MN_OR:    e = '{FMT_R,   OPC_OP,     3'd6, F7_ZERO};
            MN_AND:   e = '{FMT_R,   OPC_OP,     3'd7, F7_ZERO};
            MN_SLL:   e = '{FMT_R,   OPC_OP,     3'd1, F7_ZERO};
            MN_SRL:   e = '{FMT_R,   OPC_OP,     3'd5, F7_ZERO};
            MN_SRA:   e = '{FMT_R,   OPC_OP,     3'd5, F7_ALT};
            MN_SLT:   e = '{FMT_R,   OPC_OP,     3'd2, F7_ZERO};
            MN_SLTU:  e = '{FMT_R,   OPC_OP,     3'd3, F7_ZERO};
            MN_ADDI:  e = '{FMT_I,   OPC_OP_IMM, 3'd0, F7_ZERO};
            MN_XORI:  e = '{FMT_I,   OPC_OP_IMM, 3'd4, F7_ZERO};
            MN_ORI:   e = '{FMT_I,   OPC_OP_IMM, 3'd6, F7_ZERO};
            MN_ANDI:  e = '{FMT_I,   OPC_OP_IMM, 3'd7, F7_ZERO};
            MN_SLLI:  e = '{FMT_SH,  OPC_OP_IMM, 3'd1, F7_ZERO};
            MN_SRLI:  e = '{FMT_SH,  OPC_OP_IMM, 3'd5, F7_ZERO};
            MN_SRAI:  e = '{FMT_SH,  OPC_OP_IMM, 3'd5, F7_ALT};
            MN_SLTI:  e = '{FMT_I,   OPC_OP_IMM, 3'd2, F7_ZERO};
            MN_SLTIU: e = '{FMT_I,   OPC_OP_IMM, 3'd3, F7_ZERO};
            MN_LB:    e = '{FMT_I,   OPC_LOAD,   3'd0, F7_ZERO};
            MN_LH:    e = '{FMT_I,   OPC_LOAD,   3'd1, F7_ZERO};
            MN_LW:    e = '{FMT_I,   OPC_LOAD,   3'd2, F7_ZERO};
            MN_LBU:   e = '{FMT_I,   OPC_LOAD,   3'd4, F7_ZERO};
            MN_LHU:   e = '{FMT_I,   OPC_LOAD,   3'd5, F7_ZERO};
            MN_JALR:  e = '{FMT_I,   OPC_JALR,   3'd0, F7_ZERO};
            MN_SB:    e = '{FMT_S,   OPC_STORE,  3'd0, F7_ZERO};
            MN_SH:    e = '{FMT_S,   OPC_STORE,  3'd1, F7_ZERO};
            MN_SW:    e = '{FMT_S,   OPC_STORE,  3'd2, F7_ZERO};
            MN_BEQ:   e = '{FMT_B,   OPC_BRANCH, 3'd0, F7_ZERO};
            MN_BNE:   e = '{FMT_B,   OPC_BRANCH, 3'd1, F7_ZERO};
            MN_BLT:   e = '{FMT_B,   OPC_BRANCH, 3'd4, F7_ZERO};
            MN_BGE:   e = '{FMT_B,   OPC_BRANCH, 3'd5, F7_ZERO};
            MN_BLTU:  e = '{FMT_B,   OPC_BRANCH, 3'd6, F7_ZERO};
            MN_BGEU:  e = '{FMT_B,   OPC_BRANCH, 3'd7, F7_ZERO};
            MN_LUI:   e = '{FMT_U,   OPC_LUI,    3'd0, F7_ZERO};
            MN_AUIPC: e = '{FMT_U,   OPC_AUIPC,  3'd0, F7_ZERO};
            MN_JAL:   e = '{FMT_J,   OPC_JAL,    3'd0, F7_ZERO};
            MN_NOP:   e = '{FMT_NOP, OPC_OP_IMM, 3'd0, F7_ZERO};
            MN_MV:    e = '{FMT_MV,  OPC_OP_IMM, 3'd0, F7_ZERO};
            MN_NOT:   e = '{FMT_NOT, OPC_OP_IMM, 3'd4, F7_ZERO};
            default:  e = '{FMT_NOP, OPC_OP_IMM, 3'd0, F7_ZERO};
        endcase
        return e;
    endfunction

endpackage

>>> rtl/rvenc_front.sv
// Front end of the RV32I encoder: accepts input beats, drops unknown
// mnemonics, classifies the rest and pushes them to the queue.
// Depends on rvenc_pkg.
module rvenc_front
    import rvenc_pkg::*;
(
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [5:0]  mnemonic,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src1_reg,
    input  logic [4:0]  src2_reg,
    input  logic [31:0] immediate,
    input  logic [31:0] address_value,
    input  logic        queue_full,
    output push_t       push
);

    logic known;

    always_comb
    begin
        known                 = (mnemonic <= MN_NOT);
        item_stall            = queue_full;
        // drop unknown mnemonics: accept the beat, push nothing
        push.valid            = item_valid && !queue_full && (mode || known);
        push.entry.is_origin  = mode;
        push.entry.enc        = enc_lookup(mnemonic);
        push.entry.rd         = dest_reg;
        push.entry.rs1        = src1_reg;
        push.entry.rs2        = src2_reg;
        push.entry.imm        = immediate;
        push.entry.addr       = address_value;
    end

endmodule

>>> rtl/rvenc_queue.sv
// Short FIFO between the front and back of the RV32I encoder.
// Depends on rvenc_pkg.
module rvenc_queue
    import rvenc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output qentry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

>>> rtl/rvenc_back.sv
// Back end of the RV32I encoder: owns the location counter, computes
// branch/jump offsets, packs the instruction word and holds the result register.
// Depends on rvenc_pkg.
module rvenc_back
    import rvenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_not_empty,
    input  qentry_t     head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] instruction_word,
    output logic [31:0] word_address,
    output logic        status
);

    logic [31:0] counter_reg, counter_next;
    logic        valid_reg,   valid_next;
    logic [31:0] word_reg,    word_next;
    logic [31:0] addr_reg,    addr_next;
    logic        status_reg,  status_next;

    logic        slot_free;
    logic [31:0] off;
    logic [31:0] word;
    logic        odd;

    assign slot_free        = !valid_reg || !result_stall;
    assign pop              = queue_not_empty && slot_free;
    assign result_valid     = valid_reg;
    assign instruction_word = word_reg;
    assign word_address     = addr_reg;
    assign status           = status_reg;

    // Pack the word for the head entry
    always_comb
    begin
        off  = head.addr - counter_reg;
        odd  = 1'b0;
        word = '0;
        case (head.enc.fmt)
            FMT_R:
                word = {head.enc.f7, head.rs2, head.rs1, head.enc.f3, head.rd,
                        head.enc.opcode};
            FMT_I:
                word = {head.imm[11:0], head.rs1, head.enc.f3, head.rd, head.enc.opcode};
            FMT_SH:
                word = {head.enc.f7, head.imm[4:0], head.rs1, head.enc.f3, head.rd,
                        head.enc.opcode};
            FMT_S:
                word = {head.imm[11:5], head.rs2, head.rs1, head.enc.f3, head.imm[4:0],
                        head.enc.opcode};
            FMT_B:
            begin
                odd  = off[0];
                word = {off[12], off[10:5], head.rs2, head.rs1, head.enc.f3, off[4:1],
                        off[11], head.enc.opcode};
            end
            FMT_U:
                word = {head.imm[19:0], head.rd, head.enc.opcode};
            FMT_J:
            begin
                odd  = off[0];
                word = {off[20], off[10:1], off[11], off[19:12], head.rd, head.enc.opcode};
            end
            FMT_NOP:
                word = NOP_WORD;
            FMT_MV:
                word = {12'd0, head.rs1, head.enc.f3, head.rd, head.enc.opcode};
            FMT_NOT:
                word = {IMM_ONES, head.rs1, head.enc.f3, head.rd, head.enc.opcode};
            default:
                word = '0;
        endcase
        if (odd)
        begin
            word = '0;
        end
    end

    always_comb
    begin
        counter_next = counter_reg;
        valid_next   = valid_reg;
        word_next    = word_reg;
        addr_next    = addr_reg;
        status_next  = status_reg;
        if (slot_free)
        begin
            valid_next = pop && !head.is_origin;
        end
        if (pop)
        begin
            if (head.is_origin)
            begin
                counter_next = head.addr;
            end
            else
            begin
                word_next   = word;
                addr_next   = counter_reg;
                status_next = odd;
                // hold the counter on an odd offset
                if (!odd)
                begin
                    counter_next = counter_reg + WORD_STRIDE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        addr_reg   <= addr_next;
        status_reg <= status_next;
    end

endmodule

>>> rtl/rv32i_instruction_encoder.sv
// Top level of the RV32I instruction encoder: front end, queue and back end.
// Depends on rvenc_pkg, rvenc_front, rvenc_queue and rvenc_back.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one beat per instruction
//   or origin directive. mode = 1 loads address_value into the location
//   counter and yields no result. mode = 0 encodes the mnemonic; an index
//   above the last mnemonic is accepted and dropped.
//   Output channel (result_valid / result_stall) carries the encoded word,
//   the counter value at which it lies and a status bit. An odd branch or
//   jal offset gives word zero, status 1, and leaves the counter where it is.
//   Path: an accepted beat is written into the queue and moves on into the
//   result register when the back end is free; result_valid rises as it loads.
//   Throughput: one beat per cycle while the receiver does not stall, set by
//   the back end that pops one queue entry and packs one word per cycle.
//   Stall: when the receiver stalls, the result register holds, the back end
//   stops popping and the queue of QUEUE_DEPTH entries absorbs new beats;
//   item_stall rises only once the queue is full.
//   Reset: rst_n clears the counter to zero, empties the queue and drops any
//   pending result.
module rv32i_instruction_encoder
    import rvenc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4   // 2..16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [5:0]  mnemonic,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src1_reg,
    input  logic [4:0]  src2_reg,
    input  logic [31:0] immediate,
    input  logic [31:0] address_value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] instruction_word,
    output logic [31:0] word_address,
    output logic        status
);

    push_t   push;
    logic    queue_full;
    logic    queue_not_empty;
    logic    pop;
    qentry_t head;

    // Classify and filter incoming beats
    rvenc_front u_front (
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .mnemonic      (mnemonic),
        .dest_reg      (dest_reg),
        .src1_reg      (src1_reg),
        .src2_reg      (src2_reg),
        .immediate     (immediate),
        .address_value (address_value),
        .queue_full    (queue_full),
        .push          (push)
    );

    // Decouple front from back so each side stalls on its own
    rvenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // Advance the location counter and emit encoded words
    rvenc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .queue_not_empty  (queue_not_empty),
        .head             (head),
        .pop              (pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .instruction_word (instruction_word),
        .word_address     (word_address),
        .status           (status)
    );

endmodule

>>> sim/tb_rv32i_instruction_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for rv32i_instruction_encoder: directed and random beats
// against an in-bench encoder with its own location counter. Depends on rvenc_pkg.
module tb_rv32i_instruction_encoder;
    import rvenc_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX   = 10;

    // One input beat as the bench builds it
    typedef struct packed {
        logic        mode;
        logic [5:0]  mn;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] addr;
    } asm_beat_t;

    // One result beat as the encoder should emit it
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] addr;
        logic        status;
    } enc_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        mode;
    logic [5:0]  mnemonic;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [31:0] address_value;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] instruction_word;
    logic [31:0] word_address;
    logic        status;

    // Bench copy of the location counter and the words still owed by the encoder
    logic [31:0] loc_counter = 32'd0;
    enc_result_t pending_words[$];

    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned origins_sent   = 0;
    int unsigned words_checked  = 0;
    int unsigned odd_seen       = 0;
    int unsigned cycle_count    = 0;

    // Idle control: stimulus sets tx_quiet, rx_quiet, hold_ticket; receiver the rest
    bit          tx_quiet     = 1'b0;
    logic        rx_quiet     = 1'b0;
    int unsigned hold_ticket  = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;

    rv32i_instruction_encoder DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .mode             (mode),
        .mnemonic         (mnemonic),
        .dest_reg         (dest_reg),
        .src1_reg         (src1_reg),
        .src2_reg         (src2_reg),
        .immediate        (immediate),
        .address_value    (address_value),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .instruction_word (instruction_word),
        .word_address     (word_address),
        .status           (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort the run as a timeout, whether or not the encoder still makes progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, pending_words.size());
            $display("tb_rv32i_instruction_encoder: FAIL");
            $finish;
        end
    end

    // Receiver: stall about a third of the cycles, drop stall in quiet stretches,
    // and hold stall while hold_left counts down after each bump of hold_ticket.
    always @(posedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen    <= hold_ticket;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (rx_quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 33);
    end

    // funct3 of a register-register operation, indexed by its mnemonic
    function automatic logic [2:0] alu_f3(input logic [5:0] r_op);
        logic [2:0] f3;
        case (r_op)
            MN_SLL:          f3 = 3'b001;
            MN_SLT:          f3 = 3'b010;
            MN_SLTU:         f3 = 3'b011;
            MN_XOR:          f3 = 3'b100;
            MN_SRL, MN_SRA:  f3 = 3'b101;
            MN_OR:           f3 = 3'b110;
            MN_AND:          f3 = 3'b111;
            default:         f3 = 3'b000;   // add, sub
        endcase
        return f3;
    endfunction

    // Encode one accepted beat, queue the word it owes and advance the counter
    function automatic void predict_word(input asm_beat_t b);
        enc_result_t res;
        logic [31:0] off;
        logic [5:0]  r_op;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic        odd;
        if (b.mode)
        begin
            // origin directive: move the counter, owe nothing
            loc_counter = b.addr;
            origins_sent++;
            return;
        end
        if (b.mn > MN_NOT)
            return;                         // unknown index: dropped silently
        off = b.addr - loc_counter;
        odd = 1'b0;
        if (b.mn <= MN_SLTIU)
        begin
            // OP-IMM reuses funct3/funct7 of its register twin (addi->add, xori->xor...)
            if (b.mn <= MN_SLTU)
                r_op = b.mn;
            else if (b.mn == MN_ADDI)
                r_op = MN_ADD;
            else
                r_op = 6'(b.mn - MN_ADDI + MN_SUB);
            f3 = alu_f3(r_op);
            f7 = (r_op == MN_SUB || r_op == MN_SRA) ? F7_ALT : F7_ZERO;
            if (b.mn <= MN_SLTU)
                res.word = {f7, b.rs2, b.rs1, f3, b.rd, OPC_OP};
            else if (b.mn >= MN_SLLI && b.mn <= MN_SRAI)
                res.word = {f7, b.imm[4:0], b.rs1, f3, b.rd, OPC_OP_IMM};
            else
                res.word = {b.imm[11:0], b.rs1, f3, b.rd, OPC_OP_IMM};
        end
        else if (b.mn <= MN_LHU)
        begin
            // lb lh lw lbu lhu: funct3 0 1 2 4 5
            f3 = 3'(b.mn - MN_LB);
            if (f3 > 3'd2)
                f3 = f3 + 3'd1;
            res.word = {b.imm[11:0], b.rs1, f3, b.rd, OPC_LOAD};
        end
        else if (b.mn == MN_JALR)
            res.word = {b.imm[11:0], b.rs1, 3'b000, b.rd, OPC_JALR};
        else if (b.mn <= MN_SW)
            res.word = {b.imm[11:5], b.rs2, b.rs1, 3'(b.mn - MN_SB), b.imm[4:0], OPC_STORE};
        else if (b.mn <= MN_BGEU)
        begin
            // beq bne blt bge bltu bgeu: funct3 0 1 4 5 6 7
            f3 = 3'(b.mn - MN_BEQ);
            if (f3 > 3'd1)
                f3 = f3 + 3'd2;
            odd = off[0];
            res.word = {off[12], off[10:5], b.rs2, b.rs1, f3, off[4:1], off[11], OPC_BRANCH};
        end
        else if (b.mn == MN_LUI || b.mn == MN_AUIPC)
            res.word = {b.imm[19:0], b.rd, (b.mn == MN_LUI) ? OPC_LUI : OPC_AUIPC};
        else if (b.mn == MN_JAL)
        begin
            odd = off[0];
            res.word = {off[20], off[10:1], off[11], off[19:12], b.rd, OPC_JAL};
        end
        else if (b.mn == MN_NOP)
            res.word = NOP_WORD;
        else if (b.mn == MN_MV)
            res.word = {12'd0, b.rs1, alu_f3(MN_ADD), b.rd, OPC_OP_IMM};
        else
            res.word = {IMM_ONES, b.rs1, alu_f3(MN_XOR), b.rd, OPC_OP_IMM};

        // odd offset: zero word, error status, counter holds
        if (odd)
            res.word = 32'd0;
        res.addr   = loc_counter;
        res.status = odd;
        pending_words.insert(pending_words.size(), res);
        if (!odd)
            loc_counter = loc_counter + WORD_STRIDE;
    endfunction

    function automatic asm_beat_t make_beat(input logic md, input logic [5:0] mn,
                                            input logic [4:0] rd, input logic [4:0] rs1,
                                            input logic [4:0] rs2, input logic [31:0] imm,
                                            input logic [31:0] addr);
        asm_beat_t b;
        b = '{mode: md, mn: mn, rd: rd, rs1: rs1, rs2: rs2, imm: imm, addr: addr};
        return b;
    endfunction

    // Mostly well-formed program beats with random operands; branches and jal
    // mostly land on even in-reach targets so that real words come out.
    function automatic asm_beat_t random_beat();
        asm_beat_t   b;
        logic [31:0] r;
        int unsigned pick;
        r      = $urandom;
        b.mode = 1'b0;
        b.mn   = 6'($urandom_range(MN_NOT));
        b.rd   = 5'($urandom);
        b.rs1  = 5'($urandom);
        b.rs2  = 5'($urandom);
        b.imm  = $urandom;
        b.addr = $urandom;
        pick   = $urandom_range(99);
        if (pick < 4)
        begin
            // origin, usually word aligned, with junk in the other fields
            b.mode = 1'b1;
            b.mn   = 6'($urandom);
            if ($urandom_range(3) != 0)
                b.addr[1:0] = 2'b00;
        end
        else if (pick < 7)
            b.mn = 6'($urandom_range(63, MN_NOT + 1));
        else if ((b.mn >= MN_BEQ && b.mn <= MN_BGEU) || b.mn == MN_JAL)
        begin
            pick = $urandom_range(9);
            if (pick < 8)
            begin
                if (b.mn == MN_JAL)
                    b.addr = loc_counter + {{11{r[20]}}, r[20:1], 1'b0};
                else
                    b.addr = loc_counter + {{19{r[12]}}, r[12:1], 1'b0};
            end
            else if (pick == 8)
                b.addr = loc_counter + {r[31:1], 1'b1};
            // otherwise keep the fully random target
        end
        return b;
    endfunction

    // Offer one beat, hold it until accepted, then predict its word.
    // Valid stays high after the handshake until the next call or a drain changes it.
    task automatic send_item(input asm_beat_t b);
        if (!tx_quiet && $urandom_range(99) < 33)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid    <= 1'b1;
        mode          <= b.mode;
        mnemonic      <= b.mn;
        dest_reg      <= b.rd;
        src1_reg      <= b.rs1;
        src2_reg      <= b.rs2;
        immediate     <= b.imm;
        address_value <= b.addr;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        predict_word(b);
    endtask

    // Pause the sender until every owed word has come back, then settle
    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Compare each result beat with the oldest owed word
    always @(posedge clk)
    begin : check_results
        enc_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: word %h addr %h status %b",
                             instruction_word, word_address, status);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (status)
                    odd_seen++;
                if (instruction_word !== want.word || word_address !== want.addr ||
                    status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch on word %0d: expected %h @%h st %b, got %h @%h st %b",
                                 words_checked, want.word, want.addr, want.status,
                                 instruction_word, word_address, status);
                end
            end
        end
    end

    // Every mnemonic once, operands alternating between all-zero and all-one extremes
    task automatic test_every_mnemonic();
        asm_beat_t b;
        int        i;
        logic      hi;
        for (i = 0; i <= MN_NOT; i++)
        begin
            hi = i[0];
            b  = make_beat(1'b0, 6'(i), hi ? 5'd31 : 5'd0, hi ? 5'd0 : 5'd31,
                           hi ? 5'd31 : 5'd0, hi ? 32'hFFFF_FFFF : 32'h8000_0000,
                           32'hFFFF_FFFF);
            // branch and jump targets at the far ends of their reach
            if (i >= MN_BEQ && i <= MN_BGEU)
                b.addr = loc_counter + (hi ? 32'h0000_0FFE : 32'hFFFF_F000);
            else if (i == MN_JAL)
                b.addr = loc_counter + 32'hFFF0_0000;
            send_item(b);
        end
        drain_results();
    endtask

    task automatic test_special_cases();
        // counter wrap: park near the top and step across zero
        send_item(make_beat(1'b1, 6'h3F, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFF8));
        repeat (3)
            send_item(make_beat(1'b0, MN_ADD, 5'd1, 5'd2, 5'd3, 32'd0, 32'd0));
        send_item(make_beat(1'b1, MN_ADD, 5'd0, 5'd0, 5'd0, 32'd0, 32'h0000_1000));
        // odd offsets: error beats, counter holds for the addi after them
        send_item(make_beat(1'b0, MN_BEQ, 5'd0, 5'd5, 5'd6, 32'd0, loc_counter + 32'd3));
        send_item(make_beat(1'b0, MN_JAL, 5'd1, 5'd0, 5'd0, 32'd0, loc_counter - 32'd1));
        send_item(make_beat(1'b0, MN_ADDI, 5'd7, 5'd8, 5'd0, 32'h0000_07FF, 32'd0));
        // offsets out of reach wrap silently; max forward jal; zero offset
        send_item(make_beat(1'b0, MN_BNE, 5'd0, 5'd9, 5'd10, 32'd0, loc_counter + 32'h1000));
        send_item(make_beat(1'b0, MN_JAL, 5'd31, 5'd0, 5'd0, 32'd0,
                            loc_counter + 32'h0010_0000));
        send_item(make_beat(1'b0, MN_JAL, 5'd2, 5'd0, 5'd0, 32'd0,
                            loc_counter + 32'h000F_FFFE));
        send_item(make_beat(1'b0, MN_BLT, 5'd0, 5'd1, 5'd1, 32'hFFFF_FFFF, loc_counter));
        // unknown mnemonics: no word, counter holds
        send_item(make_beat(1'b0, 6'(MN_NOT + 1), 5'd3, 5'd3, 5'd3, 32'd0, 32'd0));
        send_item(make_beat(1'b0, 6'h3F, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // shift amounts keep only immediate bits 4:0
        send_item(make_beat(1'b0, MN_SLLI, 5'd4, 5'd5, 5'd31, 32'hFFFF_FFE5, 32'd0));
        send_item(make_beat(1'b0, MN_SRAI, 5'd6, 5'd7, 5'd31, 32'h7FFF_FFFF, 32'd0));
        // pseudo-ops ignore the operands they do not use
        send_item(make_beat(1'b0, MN_NOP, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_beat(1'b0, MN_MV, 5'd12, 5'd13, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_beat(1'b0, MN_NOT, 5'd31, 5'd31, 5'd31, 32'h0000_0000, 32'h0));
        // odd origin makes even targets odd offsets
        send_item(make_beat(1'b1, MN_NOP, 5'd0, 5'd0, 5'd0, 32'd0, 32'h0000_0003));
        send_item(make_beat(1'b0, MN_BGEU, 5'd0, 5'd2, 5'd3, 32'd0, 32'h0000_0010));
        send_item(make_beat(1'b0, MN_JAL, 5'd1, 5'd0, 5'd0, 32'd0, 32'h0000_0004));
        send_item(make_beat(1'b1, MN_NOP, 5'd0, 5'd0, 5'd0, 32'd0, 32'h0000_0000));
        drain_results();
    endtask

    task automatic test_random_program(input int unsigned count);
        repeat (count)
            send_item(random_beat());
        drain_results();
    endtask

    // Long stretch with neither side idling
    task automatic test_quiet_stretch(input int unsigned count);
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
        repeat (count)
            send_item(random_beat());
        rx_quiet <= 1'b0;
        tx_quiet = 1'b0;
        drain_results();
    endtask

    // Hold the output off while the sender keeps offering beats: the queue
    // fills and item_stall rises, then everything drains in order.
    task automatic test_backpressure(input int unsigned count);
        tx_quiet = 1'b1;
        hold_ticket <= hold_ticket + 1;
        repeat (count)
            send_item(random_beat());
        tx_quiet = 1'b0;
        drain_results();
    endtask

    initial
    begin
        // drive every input to a known value from time zero
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        mode          = 1'b0;
        mnemonic      = 6'd0;
        dest_reg      = 5'd0;
        src1_reg      = 5'd0;
        src2_reg      = 5'd0;
        immediate     = 32'd0;
        address_value = 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_every_mnemonic();
        test_special_cases();
        test_random_program(250);
        test_quiet_stretch(150);
        test_backpressure(40);
        test_random_program(260);
        drain_results();

        if (pending_words.size() != 0)
        begin
            $display("%0d expected words never arrived", pending_words.size());
            fail_count += pending_words.size();
        end
        $display("sent %0d beats (%0d origin moves), checked %0d words, %0d odd-offset errors",
                 items_sent, origins_sent, words_checked, odd_seen);
        $display("covered all mnemonics, unknown indices, counter wrap and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb_rv32i_instruction_encoder: PASS");
        else
            $display("tb_rv32i_instruction_encoder: FAIL");
        $finish;
    end

endmodule
